// ----- src/ovs_pkg.sv -----
`default_nettype none
package ovs_pkg;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_DELETE  = 3'd1;
  localparam logic [2:0] CMD_SET_REF = 3'd2;
  localparam logic [2:0] CMD_DROP    = 3'd3;
  localparam logic [2:0] CMD_LOWEST  = 3'd4;
  localparam logic [2:0] CMD_CLOSEST = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_TOO_WIDE  = 3'd4;

  localparam logic [1:0] CFG_POINT_X   = 2'd0;
  localparam logic [1:0] CFG_POINT_Y   = 2'd1;
  localparam logic [1:0] CFG_POINT_Z   = 2'd2;
  localparam logic [1:0] CFG_COS_LIMIT = 2'd3;

  localparam logic [15:0] COS_LIMIT_RESET = 16'd16384;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        obs_id;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] score;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic [15:0]        result_id;
    logic signed [31:0] best_cosine;
    logic [4:0]         entry_total;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        handle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] score;
  } entry_t;

  // three 33-bit signed differences, and three Q2.30 unit components
  typedef logic [2:0][32:0] vec3w_t;
  typedef logic [2:0][31:0] vec3u_t;

  typedef struct packed {
    logic start;
    logic op_dot;
  } unit_req_t;

  typedef struct packed {
    logic               done;
    logic signed [34:0] dot;
  } unit_rsp_t;

  function automatic logic [32:0] pos_diff(input logic [31:0] a, input logic [31:0] b);
    pos_diff = {a[31], a} - {b[31], b};
  endfunction

endpackage
`default_nettype wire

// ----- src/ovs_vec_unit.sv -----
`default_nettype none
// Shared vector unit: normalize a difference vector to Q2.30, or take the
// dot product of a given vector with the last unit vector (result >>> 30).
module ovs_vec_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ovs_pkg::unit_req_t req_i,
  input  wire ovs_pkg::vec3w_t    vec_i,
  output ovs_pkg::vec3u_t         u_o,
  output ovs_pkg::unit_rsp_t      rsp_o
);

  localparam logic [2:0] U_IDLE  = 3'd0;
  localparam logic [2:0] U_SCALE = 3'd1;
  localparam logic [2:0] U_SQ    = 3'd2;
  localparam logic [2:0] U_SQRT  = 3'd3;
  localparam logic [2:0] U_DIV   = 3'd4;
  localparam logic [2:0] U_DOT   = 3'd5;
  localparam logic [2:0] U_DONE  = 3'd6;

  logic [2:0]         state_q;
  logic               op_dot_q;
  logic [2:0][32:0]   m_q;
  logic [2:0]         neg_q;
  logic [64:0]        acc_q;
  logic signed [65:0] prod_q;
  logic [5:0]         cnt_q;
  logic [1:0]         ax_q;
  logic [63:0]        r_q;
  logic [63:0]        bit_q;
  logic [33:0]        rem_q;
  logic [29:0]        quo_q;
  ovs_pkg::vec3u_t    u_q;

  logic [32:0]        mx;
  logic [1:0]         sel;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [63:0]        sq_try;
  logic               sq_ge;
  logic [33:0]        div_cur;
  logic               div_ge;
  logic [33:0]        div_rem;
  logic [30:0]        q_full;
  logic [31:0]        u_val;
  logic               take;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) begin
      mx = m_q[1];
    end
    if (m_q[2] > mx) begin
      mx = m_q[2];
    end
  end

  assign sel   = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
  assign mul_a = $signed(m_q[sel]);
  assign mul_b = op_dot_q ? $signed({u_q[sel][31], u_q[sel]}) : $signed(m_q[sel]);

  assign sq_try = r_q + bit_q;
  assign sq_ge  = (acc_q[63:0] >= sq_try);

  assign div_cur = (cnt_q == 6'd0) ? {1'b0, m_q[ax_q]} : {rem_q[32:0], 1'b0};
  assign div_ge  = (div_cur >= {1'b0, r_q[32:0]});
  assign div_rem = div_ge ? (div_cur - {1'b0, r_q[32:0]}) : div_cur;
  assign q_full  = {quo_q, div_ge};
  assign u_val   = neg_q[ax_q] ? (32'd0 - {1'b0, q_full}) : {1'b0, q_full};

  assign take = req_i.start && ((state_q == U_IDLE) || (state_q == U_DONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      case (state_q)
        U_IDLE, U_DONE: begin
          if (take) begin
            state_q <= req_i.op_dot ? U_DOT : U_SCALE;
          end else begin
            state_q <= U_IDLE;
          end
        end
        U_SCALE: begin
          if (mx == 33'd0) begin
            state_q <= U_DONE;
          end else if (mx[32:30] != 3'd0) begin
            state_q <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt_q == 6'd3) begin
            state_q <= U_SQRT;
          end
        end
        U_SQRT: begin
          if (cnt_q == 6'd31) begin
            state_q <= U_DIV;
          end
        end
        U_DIV: begin
          if ((cnt_q == 6'd30) && (ax_q == 2'd2)) begin
            state_q <= U_DONE;
          end
        end
        U_DOT: begin
          if (cnt_q == 6'd3) begin
            state_q <= U_DONE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE, U_DONE: begin
        if (take) begin
          op_dot_q <= req_i.op_dot;
          cnt_q    <= 6'd0;
          acc_q    <= '0;
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][32];
            if (req_i.op_dot || !vec_i[i][32]) begin
              m_q[i] <= vec_i[i];
            end else begin
              m_q[i] <= 33'd0 - vec_i[i];
            end
          end
        end
      end
      U_SCALE: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (mx == 33'd0) begin
          u_q <= '0;
        end else if (mx[32:31] != 2'd0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (!mx[30]) begin
          if (mx[30:26] == 5'd0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 4;
          end else begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end
        end
      end
      U_SQ, U_DOT: begin
        if (cnt_q != 6'd3) begin
          prod_q <= mul_a * mul_b;
        end
        if (cnt_q != 6'd0) begin
          acc_q <= acc_q + prod_q[64:0];
        end
        if (cnt_q == 6'd3) begin
          cnt_q <= 6'd0;
          r_q   <= 64'd0;
          bit_q <= 64'd1 << 62;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      U_SQRT: begin
        if (sq_ge) begin
          acc_q[63:0] <= acc_q[63:0] - sq_try;
          r_q         <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_q == 6'd31) begin
          cnt_q <= 6'd0;
          ax_q  <= 2'd0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      U_DIV: begin
        rem_q <= div_rem;
        quo_q <= q_full[29:0];
        if (cnt_q == 6'd30) begin
          u_q[ax_q] <= u_val;
          ax_q      <= ax_q + 2'd1;
          cnt_q     <= 6'd0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign u_o        = u_q;
  assign rsp_o.done = (state_q == U_DONE);
  assign rsp_o.dot  = $signed(acc_q[64:30]);

endmodule
`default_nettype wire

// ----- src/observation_view_selector.sv -----
`default_nettype none
// Observation table for one 3D point, newest entry first, up to MAX_OBS
// entries held in one single-port-write, registered-read memory. Every
// command is one transaction in and exactly one transaction out. The block
// works on one transaction at a time: in_stall_o stays high from acceptance
// until the result is loaded into the output register. Insert, delete and
// drop move entries one at a time through the memory port; lowest score
// visits the entries one at a time. Closest view is bound by the shared
// vector unit: each normalization runs scale, three squares, 32 root steps
// and 3 x 31 divide steps; the frame direction is normalized first, then
// each entry is normalized and dotted with it. No clearing pass is needed
// after reset.
module observation_view_selector #(
  parameter int MAX_OBS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ovs_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ovs_pkg::out_item_t     out_data_o
);

  localparam int IW = $clog2(MAX_OBS);
  localparam int CW = $clog2(MAX_OBS + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_UP       = 5'd2;
  localparam logic [4:0] S_UP_WR    = 5'd3;
  localparam logic [4:0] S_FIND_RD  = 5'd4;
  localparam logic [4:0] S_FIND_CHK = 5'd5;
  localparam logic [4:0] S_DEL_RD   = 5'd6;
  localparam logic [4:0] S_DEL_WR   = 5'd7;
  localparam logic [4:0] S_DROP_RD  = 5'd8;
  localparam logic [4:0] S_DROP_CHK = 5'd9;
  localparam logic [4:0] S_LOW_RD   = 5'd10;
  localparam logic [4:0] S_LOW_CHK  = 5'd11;
  localparam logic [4:0] S_FRM_WAIT = 5'd12;
  localparam logic [4:0] S_ENT_RD   = 5'd13;
  localparam logic [4:0] S_ENT_GO   = 5'd14;
  localparam logic [4:0] S_ENT_WAIT = 5'd15;
  localparam logic [4:0] S_DOT_WAIT = 5'd16;
  localparam logic [4:0] S_FIN      = 5'd17;

  // configuration
  logic [31:0] point_x_q, point_y_q, point_z_q;
  logic [15:0] cos_limit_q;

  // control state
  logic [4:0]    state_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] k_q;
  logic [CW-1:0] w_q;
  logic [15:0]   ref_id_q;
  logic          ref_valid_q;
  logic          out_valid_q;

  // working payload
  ovs_pkg::in_item_t  in_q;
  ovs_pkg::out_item_t out_q;
  ovs_pkg::entry_t    rd_q;
  ovs_pkg::entry_t    mem_q [MAX_OBS];
  ovs_pkg::vec3u_t    fu_q;
  logic [2:0]         res_status_q;
  logic               res_found_q;
  logic [15:0]        sel_id_q;
  logic [15:0]        cur_id_q;
  logic signed [31:0] low_q;
  logic signed [34:0] best_q;

  // memory port and vector unit hookup
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  ovs_pkg::entry_t    mem_wd;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  ovs_pkg::unit_req_t unit_req;
  ovs_pkg::vec3w_t    unit_vec;
  ovs_pkg::vec3u_t    unit_u;
  ovs_pkg::unit_rsp_t unit_rsp;

  logic               accept;
  logic               load_out;
  logic               keep_entry;
  logic signed [34:0] limit_ext;
  logic [CW-1:0]      k_next;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign keep_entry = ref_valid_q && (rd_q.handle == ref_id_q);
  assign limit_ext  = $signed({4'd0, cos_limit_q, 15'd0});
  assign k_next     = CW'(k_q + 1'b1);

  ovs_vec_unit u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .vec_i  (unit_vec),
    .u_o    (unit_u),
    .rsp_o  (unit_rsp)
  );

  // Configuration writes; issue them only while the block is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q   <= 32'd0;
      point_y_q   <= 32'd0;
      point_z_q   <= 32'd0;
      cos_limit_q <= ovs_pkg::COS_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ovs_pkg::CFG_POINT_X:   point_x_q   <= cfg_data_i;
        ovs_pkg::CFG_POINT_Y:   point_y_q   <= cfg_data_i;
        ovs_pkg::CFG_POINT_Z:   point_z_q   <= cfg_data_i;
        ovs_pkg::CFG_COS_LIMIT: cos_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Memory access and unit requests, decoded from the sequencer state.
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = IW'(k_q);
    mem_wd   = rd_q;
    rd_en    = 1'b0;
    rd_addr  = IW'(k_q);
    unit_req = '0;
    unit_vec = '0;
    case (state_q)
      S_DISP: begin
        // normalize the point-to-frame direction first
        unit_vec[0] = ovs_pkg::pos_diff(in_q.cam_x, point_x_q);
        unit_vec[1] = ovs_pkg::pos_diff(in_q.cam_y, point_y_q);
        unit_vec[2] = ovs_pkg::pos_diff(in_q.cam_z, point_z_q);
        unit_req.start = (in_q.command == ovs_pkg::CMD_CLOSEST) && (count_q != '0);
      end
      S_UP: begin
        if (k_q == '0) begin
          mem_we        = 1'b1;
          mem_wd.handle = in_q.obs_id;
          mem_wd.pos_x  = in_q.cam_x;
          mem_wd.pos_y  = in_q.cam_y;
          mem_wd.pos_z  = in_q.cam_z;
          mem_wd.score  = in_q.score;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(k_q - 1'b1);
        end
      end
      S_UP_WR, S_DEL_WR: begin
        mem_we = 1'b1;
      end
      S_FIND_RD, S_DROP_RD, S_LOW_RD, S_ENT_RD: begin
        rd_en = (k_q != count_q);
      end
      S_DEL_RD: begin
        rd_en   = (k_next < count_q);
        rd_addr = IW'(k_next);
      end
      S_DROP_CHK: begin
        mem_we = keep_entry;
        mem_wa = IW'(w_q);
      end
      S_ENT_GO: begin
        unit_vec[0]    = ovs_pkg::pos_diff(rd_q.pos_x, point_x_q);
        unit_vec[1]    = ovs_pkg::pos_diff(rd_q.pos_y, point_y_q);
        unit_vec[2]    = ovs_pkg::pos_diff(rd_q.pos_z, point_z_q);
        unit_req.start = 1'b1;
      end
      S_ENT_WAIT: begin
        for (int i = 0; i < 3; i++) unit_vec[i] = {fu_q[i][31], fu_q[i]};
        unit_req.start  = unit_rsp.done;
        unit_req.op_dot = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Output register: load from the sequencer, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sequencer: control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      w_q         <= '0;
      ref_id_q    <= 16'd0;
      ref_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          k_q     <= '0;
          w_q     <= '0;
          state_q <= S_FIN;
          case (in_q.command)
            ovs_pkg::CMD_INSERT: begin
              if (count_q < CW'(MAX_OBS)) begin
                k_q     <= count_q;
                state_q <= S_UP;
              end
            end
            ovs_pkg::CMD_DELETE: begin
              // the reference mark goes even if the id is not stored
              if (ref_valid_q && (ref_id_q == in_q.obs_id)) begin
                ref_valid_q <= 1'b0;
                ref_id_q    <= 16'd0;
              end
              if (count_q != '0) state_q <= S_FIND_RD;
            end
            ovs_pkg::CMD_SET_REF: begin
              if (count_q != '0) state_q <= S_FIND_RD;
            end
            ovs_pkg::CMD_DROP:    state_q <= S_DROP_RD;
            ovs_pkg::CMD_LOWEST: begin
              if (count_q != '0) state_q <= S_LOW_RD;
            end
            ovs_pkg::CMD_CLOSEST: begin
              if (count_q != '0) state_q <= S_FRM_WAIT;
            end
            default: ;
          endcase
        end
        S_UP: begin
          if (k_q == '0) begin
            count_q <= count_q + 1'b1;
            state_q <= S_FIN;
          end else begin
            state_q <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          k_q     <= k_q - 1'b1;
          state_q <= S_UP;
        end
        S_FIND_RD: begin
          state_q <= (k_q == count_q) ? S_FIN : S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (rd_q.handle == in_q.obs_id) begin
            if (in_q.command == ovs_pkg::CMD_SET_REF) begin
              ref_id_q    <= in_q.obs_id;
              ref_valid_q <= 1'b1;
              state_q     <= S_FIN;
            end else begin
              state_q <= S_DEL_RD;
            end
          end else begin
            k_q     <= k_next;
            state_q <= S_FIND_RD;
          end
        end
        S_DEL_RD: begin
          // close the gap: move each later entry up by one
          if (k_next >= count_q) begin
            count_q <= count_q - 1'b1;
            state_q <= S_FIN;
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          k_q     <= k_next;
          state_q <= S_DEL_RD;
        end
        S_DROP_RD: begin
          if (k_q == count_q) begin
            count_q <= w_q;
            state_q <= S_FIN;
          end else begin
            state_q <= S_DROP_CHK;
          end
        end
        S_DROP_CHK: begin
          if (keep_entry) w_q <= w_q + 1'b1;
          k_q     <= k_next;
          state_q <= S_DROP_RD;
        end
        S_LOW_RD: begin
          state_q <= (k_q == count_q) ? S_FIN : S_LOW_CHK;
        end
        S_LOW_CHK: begin
          k_q     <= k_next;
          state_q <= S_LOW_RD;
        end
        S_FRM_WAIT: begin
          if (unit_rsp.done) begin
            k_q     <= '0;
            state_q <= S_ENT_RD;
          end
        end
        S_ENT_RD: begin
          state_q <= (k_q == count_q) ? S_FIN : S_ENT_GO;
        end
        S_ENT_GO: begin
          state_q <= S_ENT_WAIT;
        end
        S_ENT_WAIT: begin
          if (unit_rsp.done) state_q <= S_DOT_WAIT;
        end
        S_DOT_WAIT: begin
          if (unit_rsp.done) begin
            k_q     <= k_next;
            state_q <= S_ENT_RD;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Sequencer: payload and result fields.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          in_q         <= in_data_i;
          res_status_q <= ovs_pkg::ST_OK;
          res_found_q  <= 1'b0;
          sel_id_q     <= 16'd0;
          best_q       <= '0;
        end
      end
      S_DISP: begin
        case (in_q.command)
          ovs_pkg::CMD_INSERT: begin
            if (count_q >= CW'(MAX_OBS)) res_status_q <= ovs_pkg::ST_FULL;
          end
          ovs_pkg::CMD_DELETE, ovs_pkg::CMD_SET_REF, ovs_pkg::CMD_LOWEST,
          ovs_pkg::CMD_CLOSEST: begin
            if (count_q == '0) res_status_q <= ovs_pkg::ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_FIND_RD: begin
        if (k_q == count_q) res_status_q <= ovs_pkg::ST_NOT_FOUND;
      end
      S_LOW_RD: begin
        if (k_q == count_q) res_found_q <= 1'b1;
      end
      S_LOW_CHK: begin
        // strict compare: the newest entry wins a tie
        if ((k_q == '0) || (rd_q.score < low_q)) begin
          low_q    <= rd_q.score;
          sel_id_q <= rd_q.handle;
        end
      end
      S_FRM_WAIT: begin
        if (unit_rsp.done) fu_q <= unit_u;
      end
      S_ENT_RD: begin
        if (k_q == count_q) begin
          if (best_q < limit_ext) begin
            res_status_q <= ovs_pkg::ST_TOO_WIDE;
          end else begin
            res_found_q <= 1'b1;
          end
        end
      end
      S_ENT_GO: begin
        cur_id_q <= rd_q.handle;
        if (k_q == '0) sel_id_q <= rd_q.handle;
      end
      S_DOT_WAIT: begin
        if (unit_rsp.done && (unit_rsp.dot > best_q)) begin
          best_q   <= unit_rsp.dot;
          sel_id_q <= cur_id_q;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_q.status      <= res_status_q;
          out_q.found       <= res_found_q;
          out_q.result_id   <= sel_id_q;
          out_q.best_cosine <= best_q[31:0];
          out_q.entry_total <= 5'(count_q);
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
